[rtl/ccs_pkg.sv]
package ccs_pkg;

  localparam int WORD_W  = 32;
  localparam int COUNT_W = 3;
  localparam int WORDS   = 16;
  localparam int CFG_W   = 64;
  localparam int INDEX_W = 3;

  typedef logic [WORDS-1:0][WORD_W-1:0] words_t;

  // Sub-step of one quarter round: selects operands and rotate distance.
  typedef logic [1:0] qstep_t;

  localparam qstep_t QSTEP_AD16 = 2'd0;
  localparam qstep_t QSTEP_CB12 = 2'd1;
  localparam qstep_t QSTEP_AD8  = 2'd2;
  localparam qstep_t QSTEP_CB7  = 2'd3;

  // Configuration register indexes.
  typedef enum logic [INDEX_W-1:0] {
    CFG_KEY_PART_0 = 3'd0,
    CFG_KEY_PART_1 = 3'd1,
    CFG_KEY_PART_2 = 3'd2,
    CFG_KEY_PART_3 = 3'd3,
    CFG_NONCE      = 3'd4
  } cfg_index_t;

  localparam logic [3:0][WORD_W-1:0] SIGMA = {
    32'h6b206574, 32'h79622d32, 32'h3320646e, 32'h61707865
  };

endpackage

[rtl/ccs_if.sv]
// Input word channel: one data word with its byte count and restart flag.
interface ccs_in_if;
  logic                          valid;
  logic                          ready;
  logic [ccs_pkg::WORD_W-1:0]    data_word;
  logic [ccs_pkg::COUNT_W-1:0]   byte_count;
  logic                          restart;

  modport source (output valid, data_word, byte_count, restart, input ready);
  modport sink   (input valid, data_word, byte_count, restart, output ready);
endinterface

// Result word channel.
interface ccs_out_if;
  logic                          valid;
  logic                          ready;
  logic [ccs_pkg::WORD_W-1:0]    out_word;

  modport source (output valid, out_word, input ready);
  modport sink   (input valid, out_word, output ready);
endinterface

[rtl/ccs_mix_unit.sv]
// Shared add-xor-rotate unit. Each use performs one quarter-round sub-step:
// sum = x + y, mix = rotl(z ^ sum, distance of the sub-step). The feed-forward
// pass uses only the sum.
module ccs_mix_unit (
  input  logic [ccs_pkg::WORD_W-1:0] x,
  input  logic [ccs_pkg::WORD_W-1:0] y,
  input  logic [ccs_pkg::WORD_W-1:0] z,
  input  ccs_pkg::qstep_t            step,
  output logic [ccs_pkg::WORD_W-1:0] sum,
  output logic [ccs_pkg::WORD_W-1:0] mix
);

  logic [ccs_pkg::WORD_W-1:0] blend;

  assign sum   = x + y;
  assign blend = z ^ sum;

  // Fixed rotate distances 16, 12, 8 and 7.
  always_comb begin
    case (step)
      ccs_pkg::QSTEP_AD16: mix = {blend[15:0], blend[31:16]};
      ccs_pkg::QSTEP_CB12: mix = {blend[19:0], blend[31:20]};
      ccs_pkg::QSTEP_AD8:  mix = {blend[23:0], blend[31:24]};
      ccs_pkg::QSTEP_CB7:  mix = {blend[24:0], blend[31:25]};
      default:             mix = blend;
    endcase
  end

endmodule

[rtl/chacha20_stream_cipher.sv]
// ChaCha20 stream cipher, 64-bit block counter and 64-bit nonce.
// word_chan carries one little-endian data word per transfer with its byte
// count and a restart flag; result_chan returns the data word XORed with the
// next keystream word on the low byte_count bytes (upper bytes unchanged).
// Key and nonce must be written through cfg_we/cfg_index/cfg_data while idle;
// the user is bound by this, and the block itself does not enforce it. A word
// that starts a keystream block (position zero, or restart set) first runs the
// block function on one shared add-xor-rotate unit: one quarter-round sub-step
// per cycle, then the feed-forward pass that adds the input words, before its
// result is registered into the output register. Every other word goes
// straight to the output state, where its result is registered.
// One word is processed at a time; the block accepts the next word while the
// previous result still waits in the output register, and holds its result
// when the receiver stalls until that register is free.
// Reset (rst, synchronous) clears the counter and word position, the key and
// nonce registers, and empties the output register.
module chacha20_stream_cipher #(
  parameter int DOUBLE_ROUNDS = 10
) (
  input  logic                         clk,
  input  logic                         rst,
  ccs_in_if.sink                       word_chan,
  ccs_out_if.source                    result_chan,
  input  logic                         cfg_we,
  input  logic [ccs_pkg::INDEX_W-1:0]  cfg_index,
  input  logic [ccs_pkg::CFG_W-1:0]    cfg_data
);

  localparam int DR_W = (DOUBLE_ROUNDS > 1) ? $clog2(DOUBLE_ROUNDS) : 1;
  localparam logic [DR_W-1:0] DR_LAST = DR_W'(DOUBLE_ROUNDS - 1);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_ROUND = 4'b0010,
    ST_FEED  = 4'b0100,
    ST_OUT   = 4'b1000
  } state_t;

  state_t state, state_next;

  logic [3:0][ccs_pkg::CFG_W-1:0] key_part;
  logic [ccs_pkg::CFG_W-1:0]      nonce_value;
  logic [63:0]                    counter;
  logic [3:0]                     pos;
  ccs_pkg::words_t                words, words_next, init_vec, round_vec;
  ccs_pkg::qstep_t                step;
  logic [2:0]                     qr;
  logic [DR_W-1:0]                dr;
  logic [3:0]                     ff_idx;
  logic [ccs_pkg::WORD_W-1:0]     data_hold, mask_hold, mask_new;
  logic                           out_valid;
  logic [ccs_pkg::WORD_W-1:0]     out_word;
  logic [63:0]                    init_cnt;
  logic                           in_acc, emit;
  logic [3:0]                     pos_eff;
  logic [ccs_pkg::WORD_W-1:0]     ux, uy, uz, usum, umix;
  logic [3:0][1:0]                row_amt;

  // Rotate row r of the 4x4 word matrix left by amt[r] columns.
  function automatic ccs_pkg::words_t rotate_rows(ccs_pkg::words_t w,
                                                  logic [3:0][1:0] amt);
    ccs_pkg::words_t res;
    logic [1:0]      col;
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        col = 2'(c) + amt[r];
        res[r*4 + c] = w[r*4 + int'(col)];
      end
    end
    return res;
  endfunction

  assign in_acc  = word_chan.valid && word_chan.ready;
  assign emit    = (state == ST_OUT) && (!out_valid || result_chan.ready);
  assign pos_eff = word_chan.restart ? 4'd0 : pos;

  assign word_chan.ready      = (state == ST_IDLE);
  assign result_chan.valid    = out_valid;
  assign result_chan.out_word = out_word;

  // Block function input: constants, key, counter and nonce.
  always_comb begin
    init_cnt = ((state == ST_IDLE) && word_chan.restart) ? 64'd0 : counter;
    for (int i = 0; i < 4; i++) begin
      init_vec[i]       = ccs_pkg::SIGMA[i];
      init_vec[4 + 2*i] = key_part[i][31:0];
      init_vec[5 + 2*i] = key_part[i][63:32];
    end
    init_vec[12] = init_cnt[31:0];
    init_vec[13] = init_cnt[63:32];
    init_vec[14] = nonce_value[31:0];
    init_vec[15] = nonce_value[63:32];
  end

  // Operands of the shared unit. The quarter round always works on column 0;
  // the rows are rotated between quarter rounds to bring the next column or
  // diagonal there.
  always_comb begin
    ux = words[0];
    uy = words[4];
    uz = words[12];
    if (state == ST_FEED) begin
      uy = init_vec[ff_idx];
    end else if (step[0]) begin
      ux = words[8];
      uy = words[12];
      uz = words[4];
    end
  end

  ccs_mix_unit u_mix (
    .x    (ux),
    .y    (uy),
    .z    (uz),
    .step (step),
    .sum  (usum),
    .mix  (umix)
  );

  // Row rotation after each quarter round. After the last column step the
  // rows are skewed so diagonals line up as columns; the last diagonal step
  // undoes the skew.
  always_comb begin
    row_amt = {2'd1, 2'd1, 2'd1, 2'd1};
    if (qr == 3'd3) begin
      row_amt = {2'd0, 2'd3, 2'd2, 2'd1};
    end else if (qr == 3'd7) begin
      row_amt = {2'd2, 2'd3, 2'd0, 2'd1};
    end
  end

  always_comb begin
    round_vec = words;
    if (step[0]) begin
      round_vec[8] = usum;
      round_vec[4] = umix;
    end else begin
      round_vec[0]  = usum;
      round_vec[12] = umix;
    end
    if (step == ccs_pkg::QSTEP_CB7) begin
      round_vec = rotate_rows(round_vec, row_amt);
    end
  end

  // Byte mask of the incoming word.
  always_comb begin
    case (word_chan.byte_count)
      3'd0:    mask_new = 32'h0000_0000;
      3'd1:    mask_new = 32'h0000_00ff;
      3'd2:    mask_new = 32'h0000_ffff;
      3'd3:    mask_new = 32'h00ff_ffff;
      default: mask_new = 32'hffff_ffff;
    endcase
  end

  // Next state and next word matrix.
  always_comb begin
    state_next = state;
    words_next = words;
    case (state)
      ST_IDLE: begin
        if (in_acc) begin
          if (pos_eff == 4'd0) begin
            words_next = init_vec;
            state_next = ST_ROUND;
          end else begin
            state_next = ST_OUT;
          end
        end
      end
      ST_ROUND: begin
        words_next = round_vec;
        if (step == ccs_pkg::QSTEP_CB7 && qr == 3'd7 && dr == DR_LAST) begin
          state_next = ST_FEED;
        end
      end
      ST_FEED: begin
        words_next = {usum, words[15:1]};
        if (ff_idx == 4'd15) begin
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        if (emit) begin
          words_next = {words[0], words[15:1]};
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      counter   <= 64'd0;
      pos       <= 4'd0;
      step      <= ccs_pkg::QSTEP_AD16;
      qr        <= 3'd0;
      dr        <= '0;
      ff_idx    <= 4'd0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (in_acc && word_chan.restart) begin
        counter <= 64'd0;
        pos     <= 4'd0;
      end
      if (in_acc) begin
        step   <= ccs_pkg::QSTEP_AD16;
        qr     <= 3'd0;
        dr     <= '0;
        ff_idx <= 4'd0;
      end
      if (state == ST_ROUND) begin
        step <= step + 2'd1;
        if (step == ccs_pkg::QSTEP_CB7) begin
          qr <= qr + 3'd1;
          if (qr == 3'd7) begin
            dr <= dr + 1'b1;
          end
        end
      end
      if (state == ST_FEED) begin
        ff_idx <= ff_idx + 4'd1;
      end
      if (emit) begin
        pos <= pos + 4'd1;
        if (pos == 4'd15) begin
          counter <= counter + 64'd1;
        end
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (result_chan.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    words <= words_next;
    if (in_acc) begin
      data_hold <= word_chan.data_word;
      mask_hold <= mask_new;
    end
    if (emit) begin
      out_word <= data_hold ^ (words[0] & mask_hold);
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      key_part    <= '0;
      nonce_value <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        ccs_pkg::CFG_KEY_PART_0: key_part[0] <= cfg_data;
        ccs_pkg::CFG_KEY_PART_1: key_part[1] <= cfg_data;
        ccs_pkg::CFG_KEY_PART_2: key_part[2] <= cfg_data;
        ccs_pkg::CFG_KEY_PART_3: key_part[3] <= cfg_data;
        ccs_pkg::CFG_NONCE:      nonce_value <= cfg_data;
        default: ;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_feed_to_out: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FEED && ff_idx == 4'd15) |=> state == ST_OUT)
    else $error("feed-forward did not end in the output state");

  a_restart_clears: assert property (@(posedge clk) disable iff (rst)
    (in_acc && word_chan.restart) |=> (counter == 64'd0 && pos == 4'd0))
    else $error("restart did not clear counter and position");

  a_mid_block_direct: assert property (@(posedge clk) disable iff (rst)
    (in_acc && !word_chan.restart && pos != 4'd0) |=> state == ST_OUT)
    else $error("word inside a block started a block generation");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (state == ST_OUT && out_valid && !result_chan.ready) |=> state == ST_OUT)
    else $error("result overwrote a word not yet taken");
`endif

endmodule
